// File: hw/rtl/lsa_pkg.sv
// Shared types, status codes and defaults for the LIFO stack allocator.
`timescale 1ns / 1ps

package lsa_pkg;

    // Default pool size in bytes and record stack depth
    localparam int unsigned POOL_BYTES_DEF  = 1024;
    localparam int unsigned STACK_DEPTH_DEF = 128;

    // Request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POOL_FULL  = 2'd1;
    localparam logic [1:0] ST_STACK_FULL = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW  = 2'd3;

    // Shift control broadcast to every record cell
    typedef struct packed {
        logic push;   // shift toward the tail, head takes the new size
        logic pop;    // shift toward the head
    } t_shift_ctl;

endpackage

// File: hw/rtl/lifo_stack_allocator.sv
// Top level of the LIFO stack allocator: bump pointer, counters and record cell chain.
//
//  Channel   | Direction | Handshake                 | Payload
//  ----------+-----------+---------------------------+--------------------------------------
//  request   | in        | start high, busy low      | i_cmd, i_size
//  result    | out       | o_valid for one cycle     | o_status, o_block_offset,
//            |           |                           | o_block_size, o_used_bytes,
//            |           |                           | o_live_count
//
//  One request per cycle; its result is registered and appears in the next cycle.
//  The newest record sits in the head cell of the chain, so push and pop both
//  finish in the cycle of the transfer and busy stays low.
//  Reset (synchronous, active low) clears the fill level, the count and o_valid;
//  the record cells need no clearing.
//  The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module lifo_stack_allocator
    import lsa_pkg::*;
#(
    parameter int unsigned POOL_BYTES  = POOL_BYTES_DEF,
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int unsigned SIZE_W     = $clog2(POOL_BYTES + 1),
    localparam int unsigned CNT_W      = $clog2(STACK_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [SIZE_W-1:0] i_size,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [SIZE_W-1:0] o_block_offset,
    output logic [SIZE_W-1:0] o_block_size,
    output logic [SIZE_W-1:0] o_used_bytes,
    output logic [CNT_W-1:0]  o_live_count
);

    localparam logic [SIZE_W:0]  POOL_LIM  = (SIZE_W + 1)'(POOL_BYTES);
    localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(STACK_DEPTH);

    logic              r_valid, n_valid;
    logic [SIZE_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_status, n_status;
    logic [SIZE_W-1:0] r_offset, n_offset;
    logic [SIZE_W-1:0] r_bsize, n_bsize;

    logic              accept;
    logic [SIZE_W:0]   alloc_sum;
    logic [SIZE_W-1:0] head_size;
    t_shift_ctl        shift_ctl;

    logic [SIZE_W-1:0] cell_val [STACK_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign alloc_sum = {1'b0, r_fill} + {1'b0, i_size};
    assign head_size = cell_val[0];

    // Request decode: an allocation checks pool, then stack, then updates; a free checks for underflow
    always_comb begin
        n_valid   = accept;
        n_fill    = r_fill;
        n_count   = r_count;
        n_status  = r_status;
        n_offset  = r_offset;
        n_bsize   = r_bsize;
        shift_ctl = '0;
        if (accept) begin
            n_status = ST_OK;
            n_offset = '0;
            n_bsize  = '0;
            if (i_cmd == CMD_ALLOC) begin
                priority if (alloc_sum > POOL_LIM) begin
                    n_status = ST_POOL_FULL;
                end else if (r_count >= DEPTH_LIM) begin
                    n_status = ST_STACK_FULL;
                end else begin
                    n_fill         = alloc_sum[SIZE_W-1:0];
                    n_count        = r_count + 1'b1;
                    n_offset       = r_fill;
                    n_bsize        = i_size;
                    shift_ctl.push = 1'b1;
                end
            end else begin
                if (r_count == '0 || r_count > DEPTH_LIM) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count       = r_count - 1'b1;
                    n_fill        = (head_size <= r_fill) ? (r_fill - head_size) : '0;
                    n_offset      = n_fill;
                    n_bsize       = head_size;
                    shift_ctl.pop = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_offset <= n_offset;
        r_bsize  <= n_bsize;
    end

    // Record chain: cell 0 is the newest record
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [SIZE_W-1:0] from_head;
        logic [SIZE_W-1:0] from_tail;
        if (g == 0) begin : g_head
            assign from_head = i_size;
        end else begin : g_mid
            assign from_head = cell_val[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_tail
            assign from_tail = '0;
        end else begin : g_body
            assign from_tail = cell_val[g+1];
        end
        lsa_cell #(
            .W (SIZE_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (shift_ctl),
            .i_from_head (from_head),
            .i_from_tail (from_tail),
            .o_value     (cell_val[g])
        );
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_block_offset = r_offset;
    assign o_block_size   = r_bsize;
    assign o_used_bytes   = r_fill;
    assign o_live_count   = r_count;

    // Every transfer yields exactly one result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("missing result after request transfer");

    // Fill level and count never leave their ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= POOL_LIM[SIZE_W-1:0] || POOL_LIM[SIZE_W]) && r_count <= DEPTH_LIM)
        else $error("fill level or record count out of range");

    // A good allocation bumps the fill level by its size at the old offset
    a_alloc_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK && $past(i_cmd) == CMD_ALLOC)
            |-> (o_used_bytes == o_block_offset + o_block_size
                 && o_live_count == $past(r_count) + 1'b1))
        else $error("allocation did not bump fill level");

    // A good free returns the fill level to the freed block's offset
    a_free_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK && $past(i_cmd) == CMD_FREE)
            |-> (o_used_bytes == o_block_offset
                 && o_live_count == $past(r_count) - 1'b1))
        else $error("free did not restore fill level");

    // Failures leave the state as it was
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK)
            |-> (o_block_size == '0 && $stable(r_fill) && $stable(r_count)))
        else $error("failed request changed state");

endmodule

// File: hw/rtl/lsa_cell.sv
// One record cell of the size stack; shifts with its neighbors on push and pop.
`timescale 1ns / 1ps

module lsa_cell
    import lsa_pkg::*;
#(
    parameter int unsigned W = 11
) (
    input  logic         i_clk,
    input  t_shift_ctl   i_ctl,
    input  logic [W-1:0] i_from_head,   // neighbor nearer the head (or new size)
    input  logic [W-1:0] i_from_tail,   // neighbor nearer the tail
    output logic [W-1:0] o_value
);

    logic [W-1:0] r_value;
    logic [W-1:0] n_value;

    // Pick the neighbor value to take this cycle
    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            n_value = i_from_head;
        end else if (i_ctl.pop) begin
            n_value = i_from_tail;
        end
    end

    // Payload only: entries past the fill count are never read
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
